>>> hw/rtl/decaying_sine_bank_synth_core_defines.svh
// Assertion macros shared by the decaying sine bank RTL.
// Include this header in any file that carries concurrent checks; it needs clk and rst_n.
`ifndef DECAYING_SINE_BANK_SYNTH_CORE_DEFINES_SVH
`define DECAYING_SINE_BANK_SYNTH_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define DSBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsbs: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define DSBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsbs: same-cycle check failed");

`endif

>>> hw/rtl/dsbs_pkg.sv
// Package for the decaying sine bank: sizes, codes, interface structs and the sine table.
// No dependencies; used by every module of the block.
package dsbs_pkg;

  localparam int MAX_PARTIALS     = 16;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int SINE_AW   = $clog2(SINE_TABLE_DEPTH);
  localparam int PIDX_W    = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
  localparam int CNT_W     = $clog2(MAX_PARTIALS + 1);
  localparam int PROD_W    = 48;
  localparam int ACC_W     = PROD_W + $clog2(MAX_PARTIALS) + 1;
  localparam int GAIN_W    = 17;
  localparam int SCALE_W   = ACC_W + GAIN_W;
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);
  localparam int MUL_CNT_W = $clog2(GAIN_W + 1);
  localparam int OUT_SHIFT = 37;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0]  FULL_GAIN  = 17'h10000;
  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN = -24'sh800000;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  // Register reset values.
  localparam logic [4:0]  PCOUNT_RESET    = 5'd1;
  localparam logic [31:0] PPH_RESET       = 32'd22906492;
  localparam logic [15:0] RAMP_STEP_RESET = 16'd1366;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_PER_HZ   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP_STEP   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN_STEP = 8'd3;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_ATTACK = 2'd1,
    FUNC_RETRIG = 2'd2,
    FUNC_LOAD   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_RD, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5,
    ST_ACC, ST_DSET, ST_DIV, ST_MUL, ST_FIN
  } state_t;

  typedef struct packed {
    logic [4:0]  partial_count;
    logic [31:0] phase_per_hz;
    logic [15:0] ramp_up_step;
    logic [15:0] ramp_down_step;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic m1;
    logic wr_reload;
    logic wr_update;
    logic acc;
    logic next;
    logic div_init;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_en;
    logic active;
    logic last;
    logic div_done;
    logic mul_done;
  } stat_t;

  typedef logic signed [23:0] sine_tab_t [SINE_TABLE_DEPTH];

  // Builds the sine table at elaboration: quadrant folding and a Taylor series in Q30.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t          tab;
    logic [63:0]        turn;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        s;
    logic signed [63:0] sum;
    logic signed [63:0] val;
    logic [1:0]         quad;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      turn = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
      quad = turn[31:30];
      r    = {34'd0, turn[29:0]};
      if (quad[0]) begin
        r = 64'h4000_0000 - r;
      end
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x2) >> 30;
        case (k)
          1: begin
            term = term / 64'd6;
          end
          2: begin
            term = term / 64'd20;
          end
          3: begin
            term = term / 64'd42;
          end
          4: begin
            term = term / 64'd72;
          end
          5: begin
            term = term / 64'd110;
          end
          6: begin
            term = term / 64'd156;
          end
          default: begin
            term = term / 64'd210;
          end
        endcase
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      s   = $unsigned(sum);
      val = $signed((s * 64'd8388607 + 64'd536870912) >> 30);
      if (val > 64'sd8388607) begin
        val = 64'sd8388607;
      end
      if (quad[1]) begin
        val = -val;
      end
      tab[i] = 24'(val);
    end
    return tab;
  endfunction

endpackage

>>> hw/rtl/dsbs_ctrl.sv
// Controller state machine of the decaying sine bank: sequences each tick over the partials,
// the divider and the gain multiplier, and owns the result valid. Depends on dsbs_pkg.
module dsbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_func,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  dsbs_pkg::stat_t stat,
  output dsbs_pkg::cmd_t  cmd
);
  import dsbs_pkg::*;

  state_t st_r;
  state_t st_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    st_nxt        = st_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & out_stall;
    in_stall      = (st_r != ST_IDLE);
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_func == FUNC_TICK) begin
            st_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        st_nxt = stat.pass_en ? ST_RD : ST_FIN;
      end
      ST_RD: begin
        st_nxt = ST_S1;
      end
      ST_S1: begin
        cmd.m1 = 1'b1;
        if (stat.active) begin
          st_nxt = ST_S2;
        end else begin
          // Reload only: the partial is restarted but produces nothing.
          cmd.wr_reload = 1'b1;
          cmd.next      = 1'b1;
          st_nxt        = stat.last ? ST_FIN : ST_RD;
        end
      end
      ST_S2: begin
        st_nxt = ST_S3;
      end
      ST_S3: begin
        st_nxt = ST_S4;
      end
      ST_S4: begin
        cmd.wr_update = 1'b1;
        st_nxt        = ST_S5;
      end
      ST_S5: begin
        st_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc  = 1'b1;
        cmd.next = 1'b1;
        st_nxt   = stat.last ? ST_DSET : ST_RD;
      end
      ST_DSET: begin
        cmd.div_init = 1'b1;
        st_nxt       = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.mul_init = 1'b1;
          st_nxt       = ST_MUL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_MUL: begin
        if (stat.mul_done) begin
          st_nxt = ST_FIN;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/dsbs_datapath.sv
// Datapath of the decaying sine bank: partial stores, ramp state, the per-partial pipeline,
// the serial divider and gain multiplier, and the output register. Depends on dsbs_pkg.
module dsbs_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  dsbs_pkg::cfg_t     cfg,
  input  dsbs_pkg::cmd_t     cmd,
  output dsbs_pkg::stat_t    stat,
  input  logic [1:0]         in_func,
  input  logic [23:0]        in_base_freq,
  input  logic [3:0]         in_partial_index,
  input  logic [23:0]        in_partial_ratio,
  input  logic signed [23:0] in_start_amp,
  input  logic [23:0]        in_decay_mult,
  output logic signed [23:0] out_sample
);
  import dsbs_pkg::*;

  localparam sine_tab_t SINE_ROM = build_sine_tab();

  // Note and ramp state.
  logic [23:0]       cur_freq_r;
  logic [23:0]       cur_freq_nxt;
  logic [23:0]       pend_freq_r;
  logic [GAIN_W-1:0] ramp_r;
  logic [GAIN_W-1:0] ramp_nxt;
  logic              atk_pend_r;
  logic              ramp_down_r;
  logic              ramp_down_nxt;
  logic              ramp_up_r;
  logic              ramp_up_nxt;
  logic              reload_r;
  logic              reload_nxt;
  logic              down_v;
  logic              up_v;
  logic [GAIN_W:0]   ramp_sum;

  logic [CNT_W-1:0]        idx_r;
  logic [CNT_W-1:0]        n_act;
  logic signed [ACC_W-1:0] acc_r;

  // Partial stores with valid bits standing in for their zero reset.
  logic [23:0]             ratio_mem [MAX_PARTIALS];
  logic [23:0]             start_mem [MAX_PARTIALS];
  logic [23:0]             decay_mem [MAX_PARTIALS];
  logic [31:0]             phase_mem [MAX_PARTIALS];
  logic [23:0]             amp_mem   [MAX_PARTIALS];
  logic [MAX_PARTIALS-1:0] ld_vld_r;
  logic [MAX_PARTIALS-1:0] pa_vld_r;
  logic [PIDX_W-1:0]       ld_a;
  logic [PIDX_W-1:0]       rd_a;
  logic                    ld_we;
  logic                    pa_we;
  logic [31:0]             phase_wd;
  logic [23:0]             amp_wd;

  logic [23:0]        ratio_q;
  logic signed [23:0] start_q;
  logic [23:0]        decay_q;
  logic [31:0]        phase_q;
  logic signed [23:0] amp_q;

  // Per-partial pipeline.
  logic [31:0]        ph_r;
  logic signed [23:0] a_r;
  logic [47:0]        rf_r;
  logic signed [23:0] ya_r;
  logic signed [23:0] yb_r;
  logic [55:0]        t_r;
  logic [55:0]        lo_r;
  logic [47:0]        magd_r;
  logic signed [41:0] dprod_r;
  logic [31:0]        inc_r;
  logic signed [23:0] sine_r;
  logic signed [47:0] prod_r;
  logic [SINE_AW-1:0] rom_a;
  logic [SINE_AW-1:0] rom_b;
  logic [15:0]        frac;
  logic signed [24:0] diff;
  logic [56:0]        low_sum;
  logic [31:0]        inc_c;
  logic signed [41:0] interp;
  logic [23:0]        amp_mag;
  logic [23:0]        new_mag;
  logic [23:0]        amp_new;

  // Divider and gain multiplier.
  logic [ACC_W-1:0]     quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;
  logic [SCALE_W-1:0]   scl_r;
  logic [MUL_CNT_W-1:0] mul_cnt_r;
  logic [MUL_CNT_W-1:0] mul_bit;
  logic signed [SCALE_W:0]         scaled;
  logic signed [SCALE_W-OUT_SHIFT:0] shifted;
  logic signed [23:0]   sat_c;
  logic signed [23:0]   out_sample_r;

  // Active partial count, clamped.
  assign n_act = (32'(cfg.partial_count) > MAX_PARTIALS) ? CNT_W'(MAX_PARTIALS)
                                                           : CNT_W'(cfg.partial_count);

  assign stat.active   = (cur_freq_r != '0) && (n_act != '0);
  assign stat.pass_en  = (n_act != '0) && ((cur_freq_r != '0) || reload_r);
  assign stat.last     = ((idx_r + CNT_W'(1)) == n_act);
  assign stat.div_done = (div_cnt_r == '0);
  assign stat.mul_done = (mul_cnt_r == '0);

  // Ramp advance for a tick: a pending note request first forces a ramp down.
  always_comb begin
    down_v        = atk_pend_r | ramp_down_r;
    up_v          = atk_pend_r ? 1'b0 : ramp_up_r;
    ramp_nxt      = ramp_r;
    ramp_down_nxt = down_v;
    ramp_up_nxt   = up_v;
    cur_freq_nxt  = cur_freq_r;
    reload_nxt    = 1'b0;
    ramp_sum      = {1'b0, ramp_r} + (GAIN_W + 1)'(cfg.ramp_up_step);
    if (down_v) begin
      if (ramp_r != '0) begin
        if (cfg.ramp_down_step == '0 || GAIN_W'(cfg.ramp_down_step) >= ramp_r) begin
          ramp_nxt = '0;
        end else begin
          ramp_nxt = ramp_r - GAIN_W'(cfg.ramp_down_step);
        end
      end else begin
        ramp_down_nxt = 1'b0;
        ramp_up_nxt   = 1'b1;
        cur_freq_nxt  = pend_freq_r;
        reload_nxt    = 1'b1;
      end
    end else if (up_v) begin
      if (ramp_r < FULL_GAIN) begin
        if (cfg.ramp_up_step == '0 || ramp_sum >= {1'b0, FULL_GAIN}) begin
          ramp_nxt = FULL_GAIN;
        end else begin
          ramp_nxt = ramp_sum[GAIN_W-1:0];
        end
      end else begin
        ramp_up_nxt = 1'b0;
      end
    end
  end

  // Note state, partial counter and accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_freq_r  <= '0;
      pend_freq_r <= '0;
      ramp_r      <= FULL_GAIN;
      atk_pend_r  <= 1'b0;
      ramp_down_r <= 1'b0;
      ramp_up_r   <= 1'b0;
      reload_r    <= 1'b0;
      idx_r       <= '0;
      acc_r       <= '0;
    end else if (cmd.accept) begin
      case (func_t'(in_func))
        FUNC_TICK: begin
          cur_freq_r  <= cur_freq_nxt;
          ramp_r      <= ramp_nxt;
          ramp_down_r <= ramp_down_nxt;
          ramp_up_r   <= ramp_up_nxt;
          reload_r    <= reload_nxt;
          atk_pend_r  <= 1'b0;
          idx_r       <= '0;
          acc_r       <= '0;
        end
        FUNC_ATTACK: begin
          pend_freq_r <= in_base_freq;
          atk_pend_r  <= 1'b1;
        end
        FUNC_RETRIG: begin
          pend_freq_r <= cur_freq_r;
          atk_pend_r  <= 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd.next) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.acc) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // Store addressing and write data.
  assign ld_a     = PIDX_W'(in_partial_index);
  assign rd_a     = idx_r[PIDX_W-1:0];
  assign ld_we    = cmd.accept && (in_func == FUNC_LOAD) && (32'(in_partial_index) < MAX_PARTIALS);
  assign pa_we    = cmd.wr_reload | cmd.wr_update;
  assign phase_wd = cmd.wr_reload ? 32'd0 : ph_r + inc_r;
  assign amp_wd   = cmd.wr_reload ? start_q : amp_new;

  // Valid bits of the partial stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_vld_r <= '0;
      pa_vld_r <= '0;
    end else begin
      if (ld_we) begin
        ld_vld_r[ld_a] <= 1'b1;
      end
      if (pa_we) begin
        pa_vld_r[rd_a] <= 1'b1;
      end
    end
  end

  // Partial stores: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (ld_we) begin
      ratio_mem[ld_a] <= in_partial_ratio;
      start_mem[ld_a] <= in_start_amp;
      decay_mem[ld_a] <= in_decay_mult;
    end
    if (pa_we) begin
      phase_mem[rd_a] <= phase_wd;
      amp_mem[rd_a]   <= amp_wd;
    end
    ratio_q <= ld_vld_r[rd_a] ? ratio_mem[rd_a] : '0;
    start_q <= ld_vld_r[rd_a] ? start_mem[rd_a] : '0;
    decay_q <= ld_vld_r[rd_a] ? decay_mem[rd_a] : '0;
    phase_q <= pa_vld_r[rd_a] ? phase_mem[rd_a] : '0;
    amp_q   <= pa_vld_r[rd_a] ? amp_mem[rd_a] : '0;
  end

  // Pipeline arithmetic between the stages.
  always_comb begin
    rom_a   = ph_r[31 -: SINE_AW];
    rom_b   = rom_a + SINE_AW'(1);
    frac    = ph_r[31-SINE_AW -: 16];
    diff    = {yb_r[23], yb_r} - {ya_r[23], ya_r};
    low_sum = {25'd0, t_r[7:0], 24'd0} + {1'b0, lo_r};
    inc_c   = t_r[39:8] + {7'd0, low_sum[56:32]};
    interp  = {{2{ya_r[23]}}, ya_r, 16'd0} + dprod_r;
    amp_mag = a_r[23] ? 24'(-a_r) : 24'(a_r);
    new_mag = magd_r[47:24];
    amp_new = a_r[23] ? -new_mag : new_mag;
  end

  // Per-partial pipeline: phase and amplitude are captured once, the rest follows.
  always_ff @(posedge clk) begin
    if (cmd.m1) begin
      ph_r <= reload_r ? 32'd0 : phase_q;
      a_r  <= reload_r ? start_q : amp_q;
    end
    rf_r    <= ratio_q * cur_freq_r;
    ya_r    <= SINE_ROM[rom_a];
    yb_r    <= SINE_ROM[rom_b];
    t_r     <= rf_r[47:24] * cfg.phase_per_hz;
    lo_r    <= rf_r[23:0] * cfg.phase_per_hz;
    magd_r  <= amp_mag * decay_q;
    dprod_r <= diff * $signed({1'b0, frac});
    inc_r   <= inc_c;
    sine_r  <= interp[39:16];
    prod_r  <= sine_r * a_r;
  end

  // Restoring divider of the magnitude of the sum by the partial count.
  assign trial    = {rem_r, quo_r[ACC_W-1]};
  assign trial_ge = (trial >= {1'b0, n_act});
  assign mul_bit  = mul_cnt_r - MUL_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
      mul_cnt_r <= '0;
    end else begin
      if (cmd.div_init) begin
        div_cnt_r <= DIV_CNT_W'(ACC_W);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
      if (cmd.mul_init) begin
        mul_cnt_r <= MUL_CNT_W'(GAIN_W);
      end else if (cmd.mul_step) begin
        mul_cnt_r <= mul_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
      rem_r <= '0;
      neg_r <= acc_r[ACC_W-1];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? CNT_W'(trial - {1'b0, n_act}) : CNT_W'(trial);
      quo_r <= {quo_r[ACC_W-2:0], trial_ge};
    end
    // Gain multiply, one gain bit per cycle from the top.
    if (cmd.mul_init) begin
      scl_r <= '0;
    end else if (cmd.mul_step) begin
      scl_r <= {scl_r[SCALE_W-2:0], 1'b0} + (ramp_r[mul_bit] ? SCALE_W'(quo_r) : '0);
    end
  end

  // Sign, scale down and saturate.
  always_comb begin
    scaled  = neg_r ? -$signed({1'b0, scl_r}) : $signed({1'b0, scl_r});
    shifted = $signed(scaled[SCALE_W:OUT_SHIFT]);
    if (shifted > SAMPLE_MAX) begin
      sat_c = SAMPLE_MAX;
    end else if (shifted < SAMPLE_MIN) begin
      sat_c = SAMPLE_MIN;
    end else begin
      sat_c = shifted[23:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= stat.active ? sat_c : '0;
    end
  end

  assign out_sample = out_sample_r;

endmodule

>>> hw/rtl/decaying_sine_bank_synth_core.sv
// Top level of the decaying sine bank: configuration registers, controller and datapath.
// Depends on dsbs_pkg, dsbs_ctrl, dsbs_datapath and the assertion macro header.
`include "decaying_sine_bank_synth_core_defines.svh"

// A bank of up to MAX_PARTIALS exponentially decaying sine partials. Load, attack and
// retrigger transactions leave the block idle and return nothing. A tick transaction
// returns one sample. A sounding tick runs each of the N partials, with N the clamped
// partial count, in turn through the shared multiply pipeline, then a bit-serial divide
// by N and a bit-serial gain multiply. A silent tick (zero frequency or zero count) gives
// a zero sample; when it restarts the partials, it reloads each one first. A finished
// sample that finds the previous one still waiting is held back until that one is taken.
// While a tick is at work in_stall is high. A finished sample waits in the output
// register, and the next transaction is taken while it does. Configuration writes are
// always ready and must come only while the block is idle.
module decaying_sine_bank_synth_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [23:0]                    in_base_freq,
  input  logic [3:0]                     in_partial_index,
  input  logic [23:0]                    in_partial_ratio,
  input  logic signed [23:0]             in_start_amp,
  input  logic [23:0]                    in_decay_mult,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [23:0]             out_sample,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dsbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dsbs_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.partial_count  <= PCOUNT_RESET;
      cfg_r.phase_per_hz   <= PPH_RESET;
      cfg_r.ramp_up_step   <= RAMP_STEP_RESET;
      cfg_r.ramp_down_step <= RAMP_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PARTIAL_COUNT: begin
          cfg_r.partial_count <= cfg_wdata[4:0];
        end
        CFG_PHASE_PER_HZ: begin
          cfg_r.phase_per_hz <= cfg_wdata;
        end
        CFG_RAMP_UP_STEP: begin
          cfg_r.ramp_up_step <= cfg_wdata[15:0];
        end
        CFG_RAMP_DOWN_STEP: begin
          cfg_r.ramp_down_step <= cfg_wdata[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Controller.
  dsbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  dsbs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_base_freq     (in_base_freq),
    .in_partial_index (in_partial_index),
    .in_partial_ratio (in_partial_ratio),
    .in_start_amp     (in_start_amp),
    .in_decay_mult    (in_decay_mult),
    .out_sample       (out_sample)
  );

  // A tick keeps the block busy; other transactions leave it idle.
  `DSBS_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && in_func == FUNC_TICK, in_stall)
  `DSBS_ASSERT_NEXT(a_item_idle, in_valid && !in_stall && in_func != FUNC_TICK, !in_stall)
  // A new result only appears at the end of a tick's work.
  `DSBS_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))
  // The datapath takes an item only on a completed input transaction.
  `DSBS_ASSERT_NOW(a_accept_handshake, cmd.accept, in_valid && !in_stall)

endmodule

>>> dv/dsbs_sample_checker.sv
// Checker for the decaying sine bank: watches the configuration, input and sample channels.
// Keeps its own copy of the bank state, predicts each tick's sample and compares it.
// Depends on dsbs_pkg for sizes, function codes and register indexes.
module dsbs_sample_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [23:0]                     in_base_freq,
  input  logic [3:0]                      in_partial_index,
  input  logic [23:0]                     in_partial_ratio,
  input  logic signed [23:0]              in_start_amp,
  input  logic [23:0]                     in_decay_mult,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [23:0]              out_sample,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dsbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              err_count,
  output int                              pending
);
  import dsbs_pkg::*;

  // Sine table rebuilt independently, plus the register and bank state.
  logic signed [23:0] sine_rom [SINE_TABLE_DEPTH];
  logic [4:0]         reg_count;
  logic [31:0]        reg_phase_per_hz;
  logic [15:0]        reg_up_step;
  logic [15:0]        reg_down_step;
  logic [23:0]        ratio_mem [MAX_PARTIALS];
  logic signed [23:0] amp_init_mem [MAX_PARTIALS];
  logic [23:0]        decay_mem [MAX_PARTIALS];
  logic [31:0]        phase_mem [MAX_PARTIALS];
  logic signed [23:0] amp_mem [MAX_PARTIALS];
  logic [23:0]        cur_freq;
  logic [23:0]        next_freq;
  logic [16:0]        gain;
  bit                 note_req;
  bit                 fading_out;
  bit                 fading_in;
  logic signed [23:0] expected_samples [$];

  // One table entry: quadrant folding, then a truncating Taylor series in Q30.
  function automatic logic signed [23:0] sine_point(int i);
    longint unsigned ang;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint          acc;
    longint          v;
    int              q;
    ang = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
    q   = int'((ang >> 30) & 64'd3);
    r   = ang & 64'h3FFF_FFFF;
    if (q % 2 == 1) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    s = longint'(acc);
    v = longint'((s * 64'd8388607 + 64'd536870912) >> 30);
    if (v > 8388607) begin
      v = 8388607;
    end
    if (q >= 2) begin
      v = -v;
    end
    return v[23:0];
  endfunction

  // Linear interpolation between neighbouring entries, floored.
  function automatic longint interp_sine(logic [31:0] ph);
    logic [41:0] p;
    int          idx;
    longint      ya;
    longint      yb;
    longint      f;
    p   = 42'(ph) * 42'(SINE_TABLE_DEPTH);
    idx = int'(p >> 32);
    f   = longint'(p[31:16]);
    ya  = longint'(sine_rom[idx]);
    yb  = longint'(sine_rom[(idx + 1) % SINE_TABLE_DEPTH]);
    return (ya * 65536 + (yb - ya) * f) >>> 16;
  endfunction

  // Phase step: ratio * frequency * phase_per_hz, scaled down by 2^32.
  function automatic logic [31:0] phase_step(logic [23:0] ratio);
    logic [111:0] prod;
    prod = 112'(ratio) * 112'(cur_freq) * 112'(reg_phase_per_hz);
    return prod[63:32];
  endfunction

  // Advances the gain ramp, swapping in the new note at the bottom of the fade.
  task automatic advance_gain(int n);
    if (fading_out) begin
      if (gain > 0) begin
        if (reg_down_step == 0 || 17'(reg_down_step) >= gain) begin
          gain = '0;
        end else begin
          gain = gain - 17'(reg_down_step);
        end
      end else begin
        fading_out = 0;
        fading_in  = 1;
        cur_freq   = next_freq;
        for (int i = 0; i < n; i++) begin
          amp_mem[i]   = amp_init_mem[i];
          phase_mem[i] = '0;
        end
      end
    end else if (fading_in) begin
      if (gain < FULL_GAIN) begin
        if (reg_up_step == 0 || int'(gain) + int'(reg_up_step) >= int'(FULL_GAIN)) begin
          gain = FULL_GAIN;
        end else begin
          gain = gain + 17'(reg_up_step);
        end
      end else begin
        fading_in = 0;
      end
    end
  endtask

  // Works out the sample of one tick and moves the bank state on.
  task automatic predict_tick(output logic signed [23:0] smp);
    int          n;
    longint      a;
    longint      acc;
    longint      v;
    longint unsigned mag;
    n   = (reg_count > 5'(MAX_PARTIALS)) ? MAX_PARTIALS : int'(reg_count);
    acc = 0;
    v   = 0;
    if (note_req) begin
      note_req   = 0;
      fading_out = 1;
      fading_in  = 0;
    end
    advance_gain(n);
    if (cur_freq != 0 && n != 0) begin
      for (int i = 0; i < n; i++) begin
        a            = longint'(amp_mem[i]);
        acc          = acc + interp_sine(phase_mem[i]) * a;
        phase_mem[i] = phase_mem[i] + phase_step(ratio_mem[i]);
        mag          = longint'((a < 0) ? -a : a);
        mag          = (mag * 64'(decay_mem[i])) >> 24;
        amp_mem[i]   = (a < 0) ? -24'(mag) : 24'(mag);
      end
      v = ((acc / longint'(n)) * longint'(gain)) >>> 37;
      if (v > longint'(SAMPLE_MAX)) begin
        v = longint'(SAMPLE_MAX);
      end
      if (v < longint'(SAMPLE_MIN)) begin
        v = longint'(SAMPLE_MIN);
      end
    end
    smp = v[23:0];
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  initial begin
    err_count = 0;
    pending   = 0;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      sine_rom[i] = sine_point(i);
    end
  end

  // Follows every transaction on the three channels.
  always @(posedge clk) begin
    logic signed [23:0] smp;
    logic signed [23:0] want;
    if (!rst_n) begin
      reg_count        = PCOUNT_RESET;
      reg_phase_per_hz = PPH_RESET;
      reg_up_step      = RAMP_STEP_RESET;
      reg_down_step    = RAMP_STEP_RESET;
      for (int i = 0; i < MAX_PARTIALS; i++) begin
        ratio_mem[i]    = '0;
        amp_init_mem[i] = '0;
        decay_mem[i]    = '0;
        phase_mem[i]    = '0;
        amp_mem[i]      = '0;
      end
      cur_freq   = '0;
      next_freq  = '0;
      gain       = FULL_GAIN;
      note_req   = 0;
      fading_out = 0;
      fading_in  = 0;
      expected_samples.delete();
    end else begin
      // A sample transaction is checked against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", out_sample));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want) begin
            report_mismatch($sformatf("sample got %0d want %0d", out_sample, want));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PARTIAL_COUNT:  reg_count        = cfg_wdata[4:0];
          CFG_PHASE_PER_HZ:   reg_phase_per_hz = cfg_wdata;
          CFG_RAMP_UP_STEP:   reg_up_step      = cfg_wdata[15:0];
          CFG_RAMP_DOWN_STEP: reg_down_step    = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (func_t'(in_func))
          FUNC_ATTACK: begin
            next_freq = in_base_freq;
            note_req  = 1;
          end
          FUNC_RETRIG: begin
            next_freq = cur_freq;
            note_req  = 1;
          end
          FUNC_LOAD: begin
            if (int'(in_partial_index) < MAX_PARTIALS) begin
              ratio_mem[in_partial_index]    = in_partial_ratio;
              amp_init_mem[in_partial_index] = in_start_amp;
              decay_mem[in_partial_index]    = in_decay_mult;
            end
          end
          default: begin
            predict_tick(smp);
            expected_samples.push_back(smp);
          end
        endcase
      end
    end
    // Outstanding predictions, watched by the stimulus side.
    pending = expected_samples.size();
  end

endmodule

>>> dv/decaying_sine_bank_synth_core_tb.sv
// Testbench top for the decaying sine bank: clock, reset, stimulus and the verdict.
// Depends on dsbs_pkg, the block decaying_sine_bank_synth_core and dsbs_sample_checker.
module decaying_sine_bank_synth_core_tb;
  import dsbs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_func          = FUNC_TICK;
  logic [23:0]           in_base_freq     = '0;
  logic [3:0]            in_partial_index = '0;
  logic [23:0]           in_partial_ratio = '0;
  logic signed [23:0]    in_start_amp     = '0;
  logic [23:0]           in_decay_mult    = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic signed [23:0]    out_sample;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata        = '0;
  int                    err_count;
  int                    pending;
  int                    tx_idle_pct      = 19;
  int                    rx_stall_pct     = 68;
  int                    cycles           = 0;
  int                    sent             = 0;

  decaying_sine_bank_synth_core u_dut (.*);

  dsbs_sample_checker u_checker (.*);

  always #4 clk = ~clk;

  // The sample receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Hard limit on the length of the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one input transaction, with random idle cycles in front of it.
  task automatic send_item(func_t f, logic [23:0] freq, logic [3:0] idx, logic [23:0] ratio,
                           logic [23:0] amp, logic [23:0] decay);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_func          <= f;
    in_base_freq     <= freq;
    in_partial_index <= idx;
    in_partial_ratio <= ratio;
    in_start_amp     <= amp;
    in_decay_mult    <= decay;
    in_valid         <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic tick();
    send_item(FUNC_TICK, 24'($urandom), 4'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom));
  endtask

  // Writes one register; the caller lowers cfg_valid after a group of writes.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit taken;
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Waits for every predicted sample, then lets a trailing load settle.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(logic [4:0] cnt, logic [31:0] pph, logic [15:0] up,
                           logic [15:0] down);
    drain();
    cfg_write(CFG_PARTIAL_COUNT, 32'(cnt));
    cfg_write(CFG_PHASE_PER_HZ, pph);
    cfg_write(CFG_RAMP_UP_STEP, 32'(up));
    cfg_write(CFG_RAMP_DOWN_STEP, 32'(down));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A note sequence: reload some partials, start a note, then run ticks.
  task automatic note_sequence();
    int nloads;
    int nticks;
    nloads = $urandom_range(4);
    for (int i = 0; i < nloads; i++) begin
      send_item(FUNC_LOAD, 24'($urandom), 4'($urandom_range(7)), 24'($urandom),
                24'($urandom), 24'($urandom_range(24'hFFFFFF, 24'hF00000)));
    end
    if ($urandom_range(3) == 0) begin
      send_item(FUNC_RETRIG, 24'($urandom), 4'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom));
    end else begin
      send_item(FUNC_ATTACK, ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom), 4'($urandom),
                24'($urandom), 24'($urandom), 24'($urandom));
    end
    nticks = $urandom_range(30, 5);
    for (int i = 0; i < nticks; i++) begin
      tick();
    end
  endtask

  // Anything at all, any function with random fields.
  task automatic noise_item();
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      tick();
    end else if (r < 65) begin
      send_item(FUNC_ATTACK, 24'($urandom), 4'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom));
    end else if (r < 75) begin
      send_item(FUNC_RETRIG, 24'($urandom), 4'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom));
    end else begin
      send_item(FUNC_LOAD, 24'($urandom), 4'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom));
    end
  endtask

  task automatic random_phase(int budget);
    int stop_at;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        note_sequence();
      end else begin
        noise_item();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: silence at zero frequency, field extremes, note changes and ramps.
    configure(5'd4, PPH_RESET, 16'd16384, 16'd16384);
    tick();
    send_item(FUNC_LOAD, '0, 4'd0, 24'h010000, 24'h7FFFFF, 24'hFFFFFF);
    send_item(FUNC_LOAD, '0, 4'd1, 24'hFFFFFF, 24'h800000, 24'h000000);
    send_item(FUNC_LOAD, '0, 4'd2, 24'h000000, 24'h000000, 24'h800000);
    send_item(FUNC_LOAD, '0, 4'd15, 24'h020000, 24'hFFFFFF, 24'hFFFFF0);
    send_item(FUNC_ATTACK, 24'hFFFFFF, '0, '0, '0, '0);
    send_item(FUNC_RETRIG, '0, '0, '0, '0, '0);
    send_item(FUNC_ATTACK, 24'd112640, '0, '0, '0, '0);
    repeat (11) tick();
    send_item(FUNC_RETRIG, '0, '0, '0, '0, '0);
    repeat (3) tick();

    // Zero partials, zero ramp steps and the largest phase step; index 9 is unmapped.
    configure(5'd0, 32'hFFFF_FFFF, 16'd0, 16'd0);
    cfg_write(8'd9, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    tick();
    send_item(FUNC_ATTACK, 24'd256, '0, '0, '0, '0);
    repeat (2) tick();
    configure(5'd31, 32'hFFFF_FFFF, 16'd0, 16'd0);
    send_item(FUNC_RETRIG, '0, '0, '0, '0, '0);
    repeat (3) tick();

    // Random part in three idling regimes.
    tx_idle_pct  = 19;
    rx_stall_pct = 68;
    configure(5'd3, PPH_RESET, 16'd4000, 16'd65535);
    random_phase(430);
    drain();
    tx_idle_pct  = 68;
    rx_stall_pct = 19;
    configure(5'd31, 32'($urandom), 16'd65535, 16'd6000);
    random_phase(430);
    drain();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    configure(5'd7, 32'h0800_0000, 16'd1, 16'd20000);
    random_phase(430);

    drain();
    repeat (400) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/dsbs_pkg.sv
hw/rtl/dsbs_ctrl.sv
hw/rtl/dsbs_datapath.sv
hw/rtl/decaying_sine_bank_synth_core.sv
dv/dsbs_sample_checker.sv
dv/decaying_sine_bank_synth_core_tb.sv
